FILE: rtl/psc_pkg.sv
// psc_pkg: shared types, codes and constants of the part sorter controller
// no dependencies; compiled first

package psc_pkg;

  // default depth of the class queue
  localparam int QUEUE_DEPTH_DEF = 16;

  // payload widths
  localparam int KIND_W     = 2;
  localparam int SAMPLE_W   = 10;
  localparam int REFLECT_W  = 11;
  localparam int CLS_W      = 2;
  localparam int DIR_W      = 2;
  localparam int STEPS_W    = 7;
  localparam int COUNT_W    = 8;
  localparam int PEND_W     = 5;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // reflectivity minimum with no sample seen yet
  localparam logic [REFLECT_W-1:0] REFLECT_NONE = 11'd1024;

  // tray rotation step counts
  localparam logic [STEPS_W-1:0] STEPS_NONE    = 7'd0;
  localparam logic [STEPS_W-1:0] STEPS_QUARTER = 7'd50;
  localparam logic [STEPS_W-1:0] STEPS_HALF    = 7'd100;

  // threshold reset values
  localparam logic [CFG_DATA_W-1:0] ALU_MAX_RST   = 10'd254;
  localparam logic [CFG_DATA_W-1:0] STEEL_MAX_RST = 10'd700;
  localparam logic [CFG_DATA_W-1:0] WHITE_MAX_RST = 10'd955;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALU_MAX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEEL_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_MAX = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_FINAL  = 2'd2,
    KIND_EXIT   = 2'd3
  } kind_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_BLACK    = 2'd0,
    CLS_ALUMINUM = 2'd1,
    CLS_WHITE    = 2'd2,
    CLS_STEEL    = 2'd3
  } class_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY_EXIT = 2'd1,
    ST_QUEUE_FULL = 2'd2
  } status_t;

  // one result item
  typedef struct packed {
    class_t               part_class;
    dir_t                 turn_dir;
    logic [STEPS_W-1:0]   turn_steps;
    class_t               tray_position;
    logic [COUNT_W-1:0]   class_count;
    logic [PEND_W-1:0]    pending;
    status_t              status;
    logic                 event_done;
  } result_t;

  // queue requests from the controller
  typedef struct packed {
    logic   push;
    logic   pop;
    class_t wr_cls;
  } fifo_req_t;

  // queue status back to the controller
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

FILE: rtl/psc_in_if.sv
// psc_in_if: input channel of the part sorter (event kind and sample)
// depends on psc_pkg

interface psc_in_if import psc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

FILE: rtl/psc_out_if.sv
// psc_out_if: result channel of the part sorter
// depends on psc_pkg

interface psc_out_if import psc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CLS_W-1:0]    part_class;
  logic [DIR_W-1:0]    turn_dir;
  logic [STEPS_W-1:0]  turn_steps;
  logic [CLS_W-1:0]    tray_position;
  logic [COUNT_W-1:0]  class_count;
  logic [PEND_W-1:0]   pending;
  logic [STATUS_W-1:0] status;
  logic                event_done;

  modport source (
    output valid, output part_class, output turn_dir, output turn_steps,
    output tray_position, output class_count, output pending, output status,
    output event_done, input ready
  );
  modport sink (
    input valid, input part_class, input turn_dir, input turn_steps,
    input tray_position, input class_count, input pending, input status,
    input event_done, output ready
  );
endinterface

FILE: rtl/part_sorter_controller.sv
// part_sorter_controller: top level of the conveyor part sorter
// depends on psc_pkg, psc_in_if, psc_out_if and psc_class_fifo
//
//   channel  | dir | payload                                          | handshake
//   ---------+-----+--------------------------------------------------+------------
//   in_ch    | in  | kind, sample                                     | valid/ready
//   out_ch   | out | part_class, turn_dir, turn_steps, tray_position, | valid/ready
//            |     | class_count, pending, status, event_done         |
//   cfg_*    | in  | cfg_index, cfg_wdata                             | cfg_we
//
// one item per cycle while out_ch.ready stays high; an input transfer passes the
// input register, then the result register. the class queue's head is read
// from a registered memory port that is kept pointing at the next head.
// reset is synchronous: thresholds return to defaults, queue empties,
// tray goes home to black, counts clear. queue storage is not cleared.
// with out_ch.ready low the result holds and one more item waits in the
// input register before in_ch.ready drops.

module part_sorter_controller import psc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  psc_in_if.sink                in_ch,
  psc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // thresholds
  logic [CFG_DATA_W-1:0] alu_max_r, steel_max_r, white_max_r;

  // input register
  logic                s1_valid_r;
  kind_t               s1_kind_r;
  logic [SAMPLE_W-1:0] s1_sample_r;

  // block state
  logic [REFLECT_W-1:0] min_r, min_nxt;
  class_t               tray_r, tray_nxt;
  logic [COUNT_W-1:0]   counts_r [4];
  logic [COUNT_W-1:0]   counts_nxt [4];

  // result register
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;

  // handshake
  logic adv, in_ready, fire;

  // queue
  fifo_req_t        freq;
  fifo_stat_t       fstat;
  class_t           head_cls;
  logic [CNT_W-1:0] fcount;
  logic [CNT_W-1:0] cnt_after;

  // datapath temporaries
  logic [SAMPLE_W-1:0] m_val;
  class_t              cls_fin;
  logic [CLS_W-1:0]    diff;
  logic [COUNT_W-1:0]  cnt_inc;

  function automatic class_t classify(
    input logic [SAMPLE_W-1:0]   m,
    input logic [CFG_DATA_W-1:0] a_max,
    input logic [CFG_DATA_W-1:0] s_max,
    input logic [CFG_DATA_W-1:0] w_max
  );
    class_t c;
    priority if (m <= a_max) c = CLS_ALUMINUM;
    else if (m <= s_max)     c = CLS_STEEL;
    else if (m <= w_max)     c = CLS_WHITE;
    else                     c = CLS_BLACK;
    return c;
  endfunction

  // pipeline advance
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ready    = !s1_valid_r || adv;
  assign fire        = s1_valid_r && adv;
  assign in_ch.ready = in_ready;

  // threshold writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alu_max_r   <= ALU_MAX_RST;
      steel_max_r <= STEEL_MAX_RST;
      white_max_r <= WHITE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALU_MAX:   alu_max_r   <= cfg_wdata;
        CFG_STEEL_MAX: steel_max_r <= cfg_wdata;
        CFG_WHITE_MAX: white_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_kind_r   <= kind_t'(in_ch.kind);
      s1_sample_r <= in_ch.sample;
    end
  end

  // per-item work
  always_comb begin
    m_val   = ({1'b0, s1_sample_r} < min_r) ? s1_sample_r : min_r[SAMPLE_W-1:0];
    cls_fin = classify(m_val, alu_max_r, steel_max_r, white_max_r);
    diff    = head_cls - tray_r;
    cnt_inc = counts_r[head_cls] + COUNT_W'(1);

    min_nxt    = min_r;
    tray_nxt   = tray_r;
    counts_nxt = counts_r;
    freq       = '{push: 1'b0, pop: 1'b0, wr_cls: cls_fin};

    res            = '0;
    res.part_class = CLS_BLACK;
    res.turn_dir   = DIR_NONE;
    res.turn_steps = STEPS_NONE;
    res.status     = ST_OK;

    unique case (s1_kind_r)
      KIND_START: begin
        min_nxt = REFLECT_NONE;
      end
      KIND_SAMPLE: begin
        min_nxt = {1'b0, m_val};
      end
      KIND_FINAL: begin
        res.part_class  = cls_fin;
        res.class_count = counts_r[cls_fin];
        if (fstat.full) begin
          res.status = ST_QUEUE_FULL;
        end else begin
          min_nxt        = {1'b0, m_val};
          freq.push      = fire;
          res.event_done = 1'b1;
        end
      end
      KIND_EXIT: begin
        if (fstat.empty) begin
          res.status = ST_EMPTY_EXIT;
        end else begin
          freq.pop             = fire;
          res.part_class       = head_cls;
          tray_nxt             = head_cls;
          counts_nxt[head_cls] = cnt_inc;
          res.class_count      = cnt_inc;
          res.event_done       = 1'b1;
          // shortest rotation, half turn goes clockwise
          unique case (diff)
            2'd1: begin
              res.turn_dir   = DIR_CW;
              res.turn_steps = STEPS_QUARTER;
            end
            2'd2: begin
              res.turn_dir   = DIR_CW;
              res.turn_steps = STEPS_HALF;
            end
            2'd3: begin
              res.turn_dir   = DIR_CCW;
              res.turn_steps = STEPS_QUARTER;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // occupancy after this item
    cnt_after = fcount;
    if (freq.push) begin
      cnt_after = fcount + CNT_W'(1);
    end else if (freq.pop) begin
      cnt_after = fcount - CNT_W'(1);
    end
    res.tray_position = tray_nxt;
    res.pending       = PEND_W'(cnt_after);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= REFLECT_NONE;
      tray_r   <= CLS_BLACK;
      counts_r <= '{default: '0};
    end else if (fire) begin
      min_r    <= min_nxt;
      tray_r   <= tray_nxt;
      counts_r <= counts_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  psc_class_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (freq),
    .stat     (fstat),
    .head_cls (head_cls),
    .count    (fcount)
  );

  // result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.part_class    = out_res_r.part_class;
  assign out_ch.turn_dir      = out_res_r.turn_dir;
  assign out_ch.turn_steps    = out_res_r.turn_steps;
  assign out_ch.tray_position = out_res_r.tray_position;
  assign out_ch.class_count   = out_res_r.class_count;
  assign out_ch.pending       = out_res_r.pending;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.event_done    = out_res_r.event_done;

  // a completed action never carries an error status
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.event_done) |-> (out_res_r.status == ST_OK))
    else $error("completed action with error status");

  // steps present exactly when the tray turns
  a_turn_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.turn_steps == STEPS_NONE) ==
                     (out_res_r.turn_dir == DIR_NONE)))
    else $error("turn steps disagree with turn direction");

  // a transferred exit moves the tray to the popped class
  a_tray_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (s1_kind_r == KIND_EXIT) && !fstat.empty) |=> (tray_r == $past(head_cls)))
    else $error("tray position not updated on exit");

endmodule

FILE: rtl/psc_class_fifo.sv
// psc_class_fifo: class queue with head and tail pointers and a registered head read
// depends on psc_pkg

module psc_class_fifo import psc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fifo_req_t                        req,
  output fifo_stat_t                       stat,
  output class_t                           head_cls,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  class_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  class_t           head_cls_r;
  logic [PTR_W-1:0] rd_addr;

  // pointer wrap for any depth
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // pointer and fill count update
  always_comb begin
    head_nxt  = req.pop  ? next_slot(head_r) : head_r;
    tail_nxt  = req.push ? next_slot(tail_r) : tail_r;
    count_nxt = count_r;
    if (req.push && !req.pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (req.pop && !req.push) begin
      count_nxt = count_r - CNT_W'(1);
    end
    rd_addr = head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // storage write and registered head read, write data forwarded on a match
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail_r] <= req.wr_cls;
    end
    if (req.push && (tail_r == rd_addr)) begin
      head_cls_r <= req.wr_cls;
    end else begin
      head_cls_r <= mem[rd_addr];
    end
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_FULL);
  assign head_cls   = head_cls_r;
  assign count      = count_r;

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("class queue count above depth");

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    req.pop |-> !stat.empty)
    else $error("pop from empty class queue");

  // no push into a full queue
  a_push_nonfull: assert property (@(posedge clk) disable iff (!rst_n)
    req.push |-> !stat.full)
    else $error("push into full class queue");

  // a lone push grows the count by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (req.push && !req.pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("class queue count not tracking push");

endmodule
